// ----- design/fed_pkg.sv -----
// fed_pkg: shared types and constants for the feedback echo delay block
// holds gain format, register index codes and the sequencer state type
// no dependencies

package fed_pkg;

	localparam int GAIN_BITS  = 17;
	localparam int GAIN_FRAC  = 16;
	localparam int DELAY_BITS = 14;

	localparam logic [GAIN_BITS-1:0] GAIN_ONE   = 17'd65536;
	localparam logic [GAIN_BITS-1:0] WET_RESET  = 17'd32768;
	localparam logic [GAIN_BITS-1:0] FB_RESET   = 17'd0;
	localparam logic [DELAY_BITS-1:0] DLY_RESET = 14'd1;

	typedef enum logic [1:0] {
		CFG_FEEDBACK = 2'd0,
		CFG_WET      = 2'd1,
		CFG_DELAY    = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MIXY,
		S_HOLDY,
		S_MIXW,
		S_WRITE
	} fed_state_t;

	// strobes from the sequencer to the datapath
	typedef struct packed {
		logic in_stall;
		logic rd_en;
		logic mix_start;
		logic sel_fb;
		logic load_d;
		logic load_y;
		logic commit;
	} fed_ctl_t;

endpackage

// ----- design/fed_dly_mem.sv -----
// fed_dly_mem: single-port-write, single-port-read synchronous delay line ram
// read data registered
// depends on nothing

module fed_dly_mem #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/fed_mix.sv -----
// fed_mix: crossfade unit, (1 - g) * a + g * b with unsigned q1.16 gain
// products registered, truncation and saturation after the register
// depends on fed_pkg

module fed_mix import fed_pkg::*; #(
	parameter int SB = 24
) (
	input  logic                  clk,
	input  logic                  start,
	input  logic signed [SB-1:0]  a,
	input  logic signed [SB-1:0]  b,
	input  logic [GAIN_BITS-1:0]  gain,
	output logic signed [SB-1:0]  result
);

	localparam int PW = SB + GAIN_BITS + 1;
	localparam logic signed [SB+1:0] HI = {3'b000, {(SB-1){1'b1}}};
	localparam logic signed [SB+1:0] LO = {3'b111, {(SB-1){1'b0}}};

	logic [GAIN_BITS-1:0] g_b;
	logic [GAIN_BITS-1:0] g_a;
	logic signed [PW-1:0] pa_s1;
	logic signed [PW-1:0] pb_s1;
	logic signed [SB+1:0] ta;
	logic signed [SB+1:0] tb;
	logic signed [SB+1:0] sum;

	// gain above one counts as one
	always_comb begin
		g_b = (gain > GAIN_ONE) ? GAIN_ONE : gain;
		g_a = GAIN_ONE - g_b;
	end

	// products hold between starts so the result stays put
	always_ff @(posedge clk) begin
		if (start) begin
			pa_s1 <= $signed({1'b0, g_a}) * a;
			pb_s1 <= $signed({1'b0, g_b}) * b;
		end
	end

	// dropping the low bits of a two's complement product is a floor
	always_comb begin
		ta  = $signed(pa_s1[PW-1:GAIN_FRAC]);
		tb  = $signed(pb_s1[PW-1:GAIN_FRAC]);
		sum = ta + tb;
		if (sum > HI) begin
			result = HI[SB-1:0];
		end else if (sum < LO) begin
			result = LO[SB-1:0];
		end else begin
			result = sum[SB-1:0];
		end
	end

endmodule

// ----- design/fed_dly_mod.sv -----
// fed_dly_mod: reduces the delay register modulo the line depth
// reciprocal multiply with one correction step when the depth is short
// depends on fed_pkg

module fed_dly_mod import fed_pkg::*; #(
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic [DELAY_BITS-1:0]    delay,
	output logic [$clog2(DEPTH)-1:0] dl,
	output logic                     settled
);

	localparam int  AW    = $clog2(DEPTH);
	localparam bit  SHORT = (DEPTH < (2 ** DELAY_BITS));
	localparam int  LAT   = SHORT ? 4 : 1;

	logic [2:0] settle_q;

	// counts down after a delay write until the reduced value is through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 3'(LAT);
		end else if (load) begin
			settle_q <= 3'(LAT);
		end else if (settle_q != 3'd0) begin
			settle_q <= settle_q - 3'd1;
		end
	end

	assign settled = (settle_q == 3'd0);

	generate
		if (SHORT) begin : g_short
			localparam int K  = DELAY_BITS + AW;
			localparam longint unsigned RECIP = (64'd1 << K) / DEPTH;
			localparam logic [K-1:0] RECIP_V = K'(RECIP);
			localparam logic [DELAY_BITS-1:0] DEPTH_D = DELAY_BITS'(DEPTH);

			logic [DELAY_BITS+K-1:0]  prod_s1;
			logic [DELAY_BITS-1:0]    dly_s1;
			logic [DELAY_BITS-1:0]    q_s2;
			logic [DELAY_BITS-1:0]    dly_s2;
			logic [DELAY_BITS+AW-1:0] qd_s3;
			logic [DELAY_BITS-1:0]    dly_s3;
			logic [DELAY_BITS-1:0]    rem;
			logic [DELAY_BITS-1:0]    rem_fix;
			logic [AW-1:0]            dl_q;

			always_ff @(posedge clk) begin
				prod_s1 <= (DELAY_BITS+K)'(delay) * (DELAY_BITS+K)'(RECIP_V);
				dly_s1  <= delay;
				q_s2    <= prod_s1[DELAY_BITS+K-1:K];
				dly_s2  <= dly_s1;
				qd_s3   <= (DELAY_BITS+AW)'(q_s2) * (DELAY_BITS+AW)'(DEPTH_D);
				dly_s3  <= dly_s2;
				dl_q    <= rem_fix[AW-1:0];
			end

			// quotient estimate is low by at most one
			always_comb begin
				rem     = dly_s3 - qd_s3[DELAY_BITS-1:0];
				rem_fix = (rem >= DEPTH_D) ? (rem - DEPTH_D) : rem;
			end

			assign dl = dl_q;
		end else begin : g_long
			logic [AW-1:0] dl_q;

			always_ff @(posedge clk) begin
				dl_q <= AW'(delay);
			end

			assign dl = dl_q;
		end
	endgenerate

endmodule

// ----- design/feedback_echo_delay.sv -----
// feedback_echo_delay: mono feedback echo over a circular delay line ram
// an accepted word is read against the line, mixed wet, then mixed with feedback and written back
// a new word is taken only once the last one is written, which waits while the output stalls
// reset: line reads as zero until written (fill tracked by write position and a wrap flag)
// input also stalls after reset and after a delay write until the reduced delay has settled
// depends on fed_pkg, fed_dly_mem, fed_mix, fed_dly_mod

module feedback_echo_delay import fed_pkg::*; #(
	parameter int LINE_DEPTH  = 16384,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [GAIN_BITS-1:0]          cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int SB = SAMPLE_BITS;
	localparam logic [AW:0]   DEPTH_W = (AW+1)'(LINE_DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(LINE_DEPTH - 1);

	fed_state_t state_q, state_d;
	fed_ctl_t   ctl;

	logic [GAIN_BITS-1:0]  feedback_gain_q;
	logic [GAIN_BITS-1:0]  wet_gain_q;
	logic [DELAY_BITS-1:0] delay_samples_q;
	logic                  cfg_wr;

	logic [AW-1:0]         pos_q;
	logic                  full_q;
	logic [AW-1:0]         dl;
	logic                  settled;
	logic [AW:0]           diff;
	logic [AW:0]           rd_wide;
	logic [AW-1:0]         rd_addr;
	logic                  rd_ok;
	logic                  rd_ok_q;
	logic [SB-1:0]         rdata;

	logic signed [SB-1:0]  x_q;
	logic signed [SB-1:0]  d_q;
	logic signed [SB-1:0]  y_q;
	logic signed [SB-1:0]  d_cur;
	logic signed [SB-1:0]  mix_a;
	logic signed [SB-1:0]  mix_b;
	logic [GAIN_BITS-1:0]  mix_g;
	logic signed [SB-1:0]  mix_res;

	logic                  out_free;
	logic                  out_valid_q;
	logic signed [SB-1:0]  sample_out_q;

	// configuration registers
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feedback_gain_q <= FB_RESET;
			wet_gain_q      <= WET_RESET;
			delay_samples_q <= DLY_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_FEEDBACK: feedback_gain_q <= cfg_data;
				CFG_WET:      wet_gain_q      <= cfg_data;
				CFG_DELAY:    delay_samples_q <= cfg_data[DELAY_BITS-1:0];
				default:      ;
			endcase
		end
	end

	fed_dly_mod #(
		.DEPTH (LINE_DEPTH)
	) u_dly_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (cfg_wr && (cfg_index == CFG_DELAY)),
		.delay   (delay_samples_q),
		.dl      (dl),
		.settled (settled)
	);

	// read address wraps below zero; entries at or past the write pointer before
	// the first wrap were never written and read as zero
	always_comb begin
		diff    = {1'b0, pos_q} - {1'b0, dl};
		rd_wide = (pos_q >= dl) ? diff : (diff + DEPTH_W);
		rd_addr = rd_wide[AW-1:0];
		rd_ok   = full_q || (rd_addr < pos_q);
	end

	fed_dly_mem #(
		.DEPTH (LINE_DEPTH),
		.WIDTH (SB)
	) u_mem (
		.clk   (clk),
		.we    (ctl.commit),
		.waddr (pos_q),
		.wdata (mix_res),
		.re    (ctl.rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign d_cur = rd_ok_q ? $signed(rdata) : '0;

	always_comb begin
		mix_a = ctl.sel_fb ? y_q : x_q;
		mix_b = ctl.sel_fb ? d_q : d_cur;
		mix_g = ctl.sel_fb ? feedback_gain_q : wet_gain_q;
	end

	fed_mix #(
		.SB (SB)
	) u_mix (
		.clk    (clk),
		.start  (ctl.mix_start),
		.a      (mix_a),
		.b      (mix_b),
		.gain   (mix_g),
		.result (mix_res)
	);

	// sequencer
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid && settled) state_d = S_MIXY;
			S_MIXY:  state_d = S_HOLDY;
			S_HOLDY: state_d = S_MIXW;
			S_MIXW:  state_d = S_WRITE;
			S_WRITE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			S_IDLE: begin
				ctl.in_stall = !settled;
				ctl.rd_en    = in_valid && settled;
			end
			S_MIXY: begin
				ctl.in_stall  = 1'b1;
				ctl.mix_start = 1'b1;
				ctl.load_d    = 1'b1;
			end
			S_HOLDY: begin
				ctl.in_stall = 1'b1;
				ctl.load_y   = 1'b1;
			end
			S_MIXW: begin
				ctl.in_stall  = 1'b1;
				ctl.mix_start = 1'b1;
				ctl.sel_fb    = 1'b1;
			end
			S_WRITE: begin
				ctl.in_stall = 1'b1;
				ctl.sel_fb   = 1'b1;
				ctl.commit   = out_free;
			end
			default: begin
				ctl.in_stall = 1'b1;
			end
		endcase
	end

	assign in_stall = ctl.in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				pos_q <= (pos_q == LAST) ? '0 : (pos_q + AW'(1));
				if (pos_q == LAST) begin
					full_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			x_q     <= sample_in;
			rd_ok_q <= rd_ok;
		end
		if (ctl.load_d) begin
			d_q <= d_cur;
		end
		if (ctl.load_y) begin
			y_q <= mix_res;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			sample_out_q <= y_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule
